// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation codes, widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int MagWidth = 31;
    localparam int ResWidth = 63;
    localparam int AccWidth = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_TWOS,
        ST_UEVEN,
        ST_VEVEN,
        ST_SUB,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: restoring divider, one quotient bit per cycle
// Divides a 64-bit dividend by a nonzero 64-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [rau_pkg::AccWidth-1:0]   i_dividend,
    input  wire logic [rau_pkg::AccWidth-1:0]   i_divisor,
    output logic                                o_done,
    output logic      [rau_pkg::AccWidth-1:0]   o_quotient
);
    localparam int CntW = $clog2(rau_pkg::AccWidth + 1);

    logic [rau_pkg::AccWidth-1:0] r_quo, n_quo;
    logic [rau_pkg::AccWidth:0]   r_rem, n_rem;
    logic [rau_pkg::AccWidth-1:0] r_dvs;
    logic [CntW-1:0]              r_cnt, n_cnt;
    logic                         r_busy, n_busy, r_done, n_done;
    logic [rau_pkg::AccWidth:0]   w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[rau_pkg::AccWidth-1:0], r_quo[rau_pkg::AccWidth-1]};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = CntW'(rau_pkg::AccWidth);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[rau_pkg::AccWidth-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[rau_pkg::AccWidth-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_dvs <= i_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> (r_busy || r_cnt == '0 || $past(i_start)))
        else $error("divider count left over");
    a_busy_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider busy with zero count");
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit: sign-magnitude fraction add/sub/mul/div with reduction
// Cross-multiplies, reduces by binary GCD, divides out the GCD.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | op, a_num, a_den, a_negative, b_num, b_den,
//          |     | b_negative (128 bits)                              | -
//  m_axis  | out | res_num, res_den, res_negative (128 bits)          | -
//
// One transaction at a time. The three multiplier states MUL0, MUL1 and MUL2
// share one 31x31 multiplier and are followed by one combine state, then the
// binary GCD at one shift or one subtract per cycle, then two divisions by the
// GCD in the shared divider. Zero results skip the GCD and the divisions.
// Reset is synchronous active low and clears the sequencer and output valid.
// s_axis_tready is high whenever the sequencer is idle; the finished result
// sits in its own output register, so a held result stalls only the next
// result, not the next input transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit #(
    parameter int MAG_WIDTH = rau_pkg::MagWidth
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // op,a_num,a_den,a_negative,b_num,b_den,b_negative
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [127:0] m_axis_tdata    // res_num,res_den,res_negative
);
    localparam int W  = rau_pkg::AccWidth;
    localparam int FM = rau_pkg::MagWidth;   // field width in tdata
    localparam int TW = $clog2(W + 1);

    rau_pkg::t_state r_st, n_st;

    // input field extraction (fixed field positions of width FM)
    logic [1:0]  w_op;
    logic [MAG_WIDTH-1:0] w_an, w_ad, w_bn, w_bd;
    assign w_op = s_axis_tdata[1:0];
    assign w_an = s_axis_tdata[2 +: MAG_WIDTH];
    assign w_ad = s_axis_tdata[2+FM +: MAG_WIDTH];
    assign w_bn = s_axis_tdata[3+2*FM +: MAG_WIDTH];
    assign w_bd = s_axis_tdata[3+3*FM +: MAG_WIDTH];

    logic [MAG_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    rau_pkg::t_op         r_op;
    logic                 r_as, r_bs, r_neg, n_neg;
    logic [W-1:0] r_p, r_q, r_den, r_num, n_p, n_q, n_den, n_num;
    logic [W-1:0] r_u, r_v, n_u, n_v;
    logic [TW-1:0] r_twos, n_twos;
    logic [W-1:0] r_rn, r_rd, n_rn, n_rd;
    logic         r_oneg, n_oneg;
    logic         r_ovld, n_ovld;
    logic [127:0] r_mdata, n_mdata;   // held output transaction
    logic         r_launch;           // first cycle of the numerator division

    // shared multiplier
    logic [MAG_WIDTH-1:0]   w_ma, w_mb;
    logic [2*MAG_WIDTH-1:0] w_prod;
    assign w_prod = w_ma * w_mb;

    // shared divider
    logic         w_dstart, w_ddone;
    logic [W-1:0] w_ddvd, w_dq, w_g;
    assign w_g = r_u << r_twos;
    rau_div u_div (
        .i_clk, .i_rst_n,
        .i_start(w_dstart), .i_dividend(w_ddvd), .i_divisor(w_g),
        .o_done(w_ddone), .o_quotient(w_dq)
    );

    logic w_beff, w_sub;
    assign w_beff = (r_op == rau_pkg::OP_SUB) ? !r_bs : r_bs;
    assign w_sub  = r_as != w_beff;

    always_comb begin
        n_st = r_st; n_p = r_p; n_q = r_q; n_den = r_den; n_num = r_num;
        n_neg = r_neg; n_u = r_u; n_v = r_v; n_twos = r_twos;
        n_rn = r_rn; n_rd = r_rd; n_oneg = r_oneg; n_ovld = r_ovld;
        n_mdata = r_mdata;
        w_ma = r_an; w_mb = r_bd; w_dstart = 1'b0; w_ddvd = r_num;
        if (r_ovld && m_axis_tready) n_ovld = 1'b0;
        case (r_st)
            rau_pkg::ST_IDLE: if (s_axis_tvalid) n_st = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0: begin
                // p: an*bd (add/sub/div) or an*bn (mul)
                w_ma = r_an;
                w_mb = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
                n_p = W'(w_prod);
                n_st = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                // q: bn*ad for add/sub; denominator for mul/div
                w_ma = r_ad;
                w_mb = (r_op == rau_pkg::OP_DIV) ? r_bn : (r_op == rau_pkg::OP_MUL) ? r_bd : r_bn;
                n_q = W'(w_prod);
                n_st = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                w_ma = r_ad; w_mb = r_bd;
                n_den = (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) ? r_q
                                                                            : W'(w_prod);
                n_st = rau_pkg::ST_COMBINE;
            end
            rau_pkg::ST_COMBINE: begin
                if (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) begin
                    n_num = r_p; n_neg = r_as != r_bs;
                end else if (!w_sub) begin
                    n_num = r_p + r_q; n_neg = r_as;
                end else if (r_p < r_q) begin
                    n_num = r_q - r_p; n_neg = w_beff;
                end else begin
                    n_num = r_p - r_q; n_neg = r_as;
                end
                n_u = n_num; n_v = r_den; n_twos = '0;
                if (n_num == '0 || r_den == '0) begin
                    n_rn = '0; n_rd = W'(1); n_oneg = 1'b0;
                    n_st = rau_pkg::ST_OUT;
                end else begin
                    n_st = rau_pkg::ST_TWOS;
                end
            end
            rau_pkg::ST_TWOS: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1; n_v = r_v >> 1; n_twos = r_twos + 1'b1;
                end else n_st = rau_pkg::ST_UEVEN;
            end
            rau_pkg::ST_UEVEN: begin
                if (!r_u[0]) n_u = r_u >> 1;
                else n_st = rau_pkg::ST_VEVEN;
            end
            rau_pkg::ST_VEVEN: begin
                if (!r_v[0]) n_v = r_v >> 1;
                else n_st = rau_pkg::ST_SUB;
            end
            rau_pkg::ST_SUB: begin
                if (r_u > r_v) begin
                    n_u = r_v; n_v = r_u - r_v;
                end else n_v = r_v - r_u;
                if (n_v == '0) begin
                    w_dstart = 1'b0;
                    n_st = rau_pkg::ST_DIVN;
                end else n_st = rau_pkg::ST_VEVEN;
            end
            rau_pkg::ST_DIVN: begin
                // first cycle: launch; later: wait for quotient, then launch denominator
                if (r_launch) begin
                    w_dstart = 1'b1; w_ddvd = r_num;
                end else if (w_ddone) begin
                    n_rn = w_dq;
                    w_dstart = 1'b1; w_ddvd = r_den;
                    n_st = rau_pkg::ST_DIVD;
                end
            end
            rau_pkg::ST_DIVD: if (w_ddone) begin
                n_rd = w_dq; n_oneg = r_neg; n_st = rau_pkg::ST_OUT;
            end
            rau_pkg::ST_OUT: if (!r_ovld) begin
                n_ovld = 1'b1;
                n_mdata = {1'b0, r_oneg, r_rd[62:0], r_rn[62:0]};
                n_st = rau_pkg::ST_IDLE;
            end
            default: n_st = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rau_pkg::ST_IDLE;
            r_ovld <= 1'b0;
            r_launch <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ovld <= n_ovld;
            r_launch <= (n_st == rau_pkg::ST_DIVN) && (r_st != rau_pkg::ST_DIVN);
        end
        if (r_st == rau_pkg::ST_IDLE) begin
            r_op <= rau_pkg::t_op'(w_op);
            r_an <= w_an; r_ad <= w_ad; r_bn <= w_bn; r_bd <= w_bd;
            r_as <= s_axis_tdata[2+2*FM];
            r_bs <= s_axis_tdata[3+4*FM];
        end
        r_p <= n_p; r_q <= n_q; r_den <= n_den; r_num <= n_num; r_neg <= n_neg;
        r_u <= n_u; r_v <= n_v; r_twos <= n_twos;
        r_rn <= n_rn; r_rd <= n_rd; r_oneg <= n_oneg;
        r_mdata <= n_mdata;
    end

    assign s_axis_tready = (r_st == rau_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_mdata;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while held");
    a_out_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[125:63] != '0) else $error("zero result denominator");
    a_zero_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[62:0] == '0) |->
        (m_axis_tdata[125:63] == 63'd1 && !m_axis_tdata[126]))
        else $error("noncanonical zero");
endmodule
`default_nettype wire

// ===== verif/rational_arith_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_tb: self-checking bench for the rational arithmetic unit
// Streams fraction pairs with all four operations, predicts each reduced
// result and compares it field by field against the output transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class frac_scoreboard;
    typedef struct packed {
        logic [62:0] num;
        logic [62:0] den;
        logic        neg;
    } t_frac;

    t_frac pending_q[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    // Stein GCD on nonzero values
    static function logic [63:0] stein_gcd(logic [63:0] u, logic [63:0] v);
        int          twos;
        logic [63:0] t;
        twos = 0;
        while (((u | v) & 64'd1) == 0) begin
            u = u >> 1;
            v = v >> 1;
            twos++;
        end
        while (u[0] == 1'b0) u = u >> 1;
        do begin
            while (v[0] == 1'b0) v = v >> 1;
            if (u > v) begin
                t = u;
                u = v;
                v = t;
            end
            v = v - u;
        end while (v != 0);
        return u << twos;
    endfunction

    // Note one accepted input transaction and queue its reduced result.
    function void note_operands(logic [127:0] d);
        rau_pkg::t_op op;
        logic [63:0]  an, ad, bn, bd, p, q, num, den, g;
        logic         as, bs, beff, neg;
        t_frac        r;
        op = rau_pkg::t_op'(d[1:0]);
        an = {33'd0, d[32:2]};
        ad = {33'd0, d[63:33]};
        as = d[64];
        bn = {33'd0, d[95:65]};
        bd = {33'd0, d[126:96]};
        bs = d[127];
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                p = an * bd;
                q = bn * ad;
                beff = (op == rau_pkg::OP_SUB) ? !bs : bs;
                den = ad * bd;
                if (as == beff) begin
                    num = p + q;
                    neg = as;
                end else if (p < q) begin
                    num = q - p;
                    neg = beff;
                end else begin
                    num = p - q;
                    neg = as;
                end
            end
            rau_pkg::OP_MUL: begin
                num = an * bn;
                den = ad * bd;
                neg = as != bs;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
                neg = as != bs;
            end
        endcase
        if (num == 0 || den == 0) begin
            r.num = '0;
            r.den = 63'd1;
            r.neg = 1'b0;
        end else begin
            g = stein_gcd(num, den);
            r.num = 63'(num / g);
            r.den = 63'(den / g);
            r.neg = neg;
        end
        pending_q.push_back(r);
    endfunction

    function void report(string what, logic [62:0] got, logic [62:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(logic [127:0] d);
        t_frac e;
        if (pending_q.size() == 0) begin
            $display("MISMATCH unexpected result transaction %h", d);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (d[62:0] !== e.num) report("res_num", d[62:0], e.num);
        if (d[125:63] !== e.den) report("res_den", d[125:63], e.den);
        if (d[126] !== e.neg) report("res_negative", 63'(d[126]), 63'(e.neg));
    endfunction
endclass

module rational_arith_unit_tb;
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // op,a_num,a_den,a_negative,b_num,b_den,b_negative
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // res_num,res_den,res_negative

    frac_scoreboard sb;
    bit             no_stall;

    rational_arith_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: 1500 random items plus the directed items and stalls
    initial begin
        #(20 * 3_000_000);
        $display("rational_arith_unit test failed");
        $finish;
    end

    function automatic logic [30:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 15));
            1: return 31'h7fffffff - 31'($urandom_range(0, 3));
            2: return 31'(1) << $urandom_range(0, 30);
            3: return 31'($urandom_range(1, 1000)) * 31'($urandom_range(1, 64));
            default: return 31'($urandom);
        endcase
    endfunction

    // One input transaction; waits out a random gap first. tvalid stays high
    // after the handshake until the next gap or the end of the stream.
    task automatic send_item(rau_pkg::t_op op, logic [30:0] an, logic [30:0] ad, logic as,
                             logic [30:0] bn, logic [30:0] bd, logic bs);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bs, bd, bn, as, ad, an, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_operands({bs, bd, bn, as, ad, an, op});
    endtask

    // Result side: random ready stalls, sample at the edge
    initial begin
        int wait_cycles;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_cycles = no_stall ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        rau_pkg::t_op ops[4];
        int           guard;
        ops = '{rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_DIV};
        sb = new();
        no_stall = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zeros, zero denominators, cancellation
        foreach (ops[k]) begin
            send_item(ops[k], 31'h7fffffff, 31'h7fffffff, 1'b1,
                      31'h7fffffff, 31'h7fffffff, 1'b1);
            send_item(ops[k], 31'h7fffffff, 31'd1, 1'b0, 31'h7fffffff, 31'd1, 1'b1);
            send_item(ops[k], 31'd1, 31'h7fffffff, 1'b1, 31'd0, 31'h7fffffff, 1'b0);
            send_item(ops[k], 31'd3, 31'd0, 1'b0, 31'd5, 31'd7, 1'b0);
            send_item(ops[k], 31'd6, 31'd4, 1'b1, 31'd3, 31'd2, 1'b0);
        end
        send_item(rau_pkg::OP_SUB, 31'd6, 31'd4, 1'b1, 31'd3, 31'd2, 1'b1);
        send_item(rau_pkg::OP_ADD, 31'd4, 31'd6, 1'b0, 31'd2, 31'd3, 1'b1);
        send_item(rau_pkg::OP_MUL, 31'd0, 31'd9, 1'b1, 31'd4, 31'd0, 1'b1);

        // random, with a stretch of back-to-back traffic
        for (int i = 0; i < 1500; i++) begin
            logic [30:0] an, ad, bn, bd;
            no_stall = (i >= 600 && i < 700);
            an = rand_mag();
            ad = rand_mag();
            bn = rand_mag();
            bd = rand_mag();
            if ($urandom_range(0, 19) != 0) begin
                if (ad == 0) ad = 31'd1;
                if (bd == 0) bd = 31'd1;
            end
            if ($urandom_range(0, 15) == 0) begin
                bn = an;
                bd = ad;
            end
            send_item(ops[$urandom_range(0, 3)], an, ad, 1'($urandom), bn, bd, 1'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        no_stall = 1'b0;

        guard = 0;
        while (sb.pending_q.size() != 0 && guard < 100_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("rational_arith_unit test passed");
        end else begin
            $display("rational_arith_unit test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== rational_arith_unit.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arith_unit.sv
verif/rational_arith_unit_tb.sv
